### rtl/tss_pkg.sv
// Package for the Taylor sine series block: widths, the reciprocal odd-factorial
// table and the beat record handed from cell to cell.
// No dependencies.
package tss_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_BITS  = 30;
  localparam int MAX_TERMS  = 6;
  localparam int IDX_W      = 3;
  localparam logic [IDX_W-1:0] LAST_TERM_RST = 3'd4;

  // reciprocal factorials are held at RECIP_BITS fractional bits
  localparam int RECIP_BITS = 62;
  // from term index 1 (the x^3 term) on, every entry is below 2^RCP_W
  localparam int RCP_W      = 60;
  localparam int RCP_HALF   = RCP_W / 2;

  // |x| <= 2.0, so x^(2k+1) in Q.30 needs DATA_W + 2k bits
  localparam int PWR_W      = DATA_W + 2 * (MAX_TERMS - 1);
  localparam int HALF_W     = PWR_W / 2;
  localparam int MAG_W      = DATA_W + 1;
  localparam int SUM_W      = DATA_W + 3;

  // round(2^62 / (2k+1)!)
  localparam logic [RECIP_BITS:0] RECIP_FACT [MAX_TERMS] = '{
    63'd4611686018427387904,
    63'd768614336404564651,
    63'd38430716820228233,
    63'd915017067148291,
    63'd12708570377060,
    63'd115532457973
  };

  typedef struct packed {
    logic [DATA_W-1:0]       ax;     // |x|
    logic                    neg;    // sign of x
    logic [IDX_W-1:0]        last;   // last term index for this beat
    logic [PWR_W-1:0]        power;  // |x|^(2k+1) in Q.FRAC_BITS
    logic signed [SUM_W-1:0] sum;    // partial series sum
  } tss_beat_t;

endpackage

### rtl/tss_if.sv
// Valid/ready channel interfaces for the angle input and the sine result.
// Depends on tss_pkg.
interface tss_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tss_pkg::DATA_W-1:0]   angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface tss_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tss_pkg::DATA_W-1:0]   sine_value;

  modport source (output valid, output sine_value, input ready);
  modport sink   (input valid, input sine_value, output ready);
endinterface

### rtl/taylor_sine_series_top.sv
// Taylor sine series: sum of (-1)^k x^(2k+1)/(2k+1)! for k = 0..min(last_term_index, MAX_TERMS-1).
// A beat passes the head register, the series cells and the output register in order.
// Throughput: one angle per cycle unless a result waits at the output; each series cell holds eight register stages.
// The whole chain advances together and holds while a result waits at the output.
// Reset: synchronous active-low; clears valid bits, last_term_index returns to 4.
// Depends on tss_pkg, tss_if and tss_cell.
module taylor_sine_series_top #(
  parameter int MAX_TERMS = tss_pkg::MAX_TERMS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tss_pkg::IDX_W-1:0]   cfg_wdata,
  tss_in_if.sink                      in_chan,
  tss_out_if.source                   out_chan
);

  localparam int DW = tss_pkg::DATA_W;
  localparam int SW = tss_pkg::SUM_W;
  localparam int PW = tss_pkg::PWR_W;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  logic [tss_pkg::IDX_W-1:0] last_term_r;
  logic                      en;
  logic                      head_vld_r;
  tss_pkg::tss_beat_t        head_r, head_nxt;
  logic [DW-1:0]             angle_u;
  logic                      out_valid_r;
  logic signed [DW-1:0]      out_data_r, sat_nxt;
  logic signed [SW-1:0]      tail_sum;

  logic [MAX_TERMS-1:0]      chain_vld;
  tss_pkg::tss_beat_t        chain_beat [MAX_TERMS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_term_r <= tss_pkg::LAST_TERM_RST;
    end else if (cfg_we) begin
      last_term_r <= cfg_wdata;
    end
  end

  // chain moves unless a finished result is stuck at the output
  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  // first term is |x| itself
  always_comb begin
    angle_u       = in_chan.angle;
    head_nxt.neg  = angle_u[DW-1];
    head_nxt.ax   = head_nxt.neg ? (~angle_u + 1'b1) : angle_u;
    head_nxt.last = last_term_r;
    head_nxt.power = PW'(head_nxt.ax);
    head_nxt.sum  = head_nxt.neg ? -$signed(SW'(head_nxt.ax)) : $signed(SW'(head_nxt.ax));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
    end else if (en) begin
      head_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      head_r <= head_nxt;
    end
  end

  assign chain_vld[0]  = head_vld_r;
  assign chain_beat[0] = head_r;

  for (genvar k = 1; k < MAX_TERMS; k++) begin : g_cell
    tss_cell #(
      .TERM_IDX (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .up_valid (chain_vld[k-1]),
      .up_beat  (chain_beat[k-1]),
      .dn_valid (chain_vld[k]),
      .dn_beat  (chain_beat[k])
    );
  end

  always_comb begin
    tail_sum = chain_beat[MAX_TERMS-1].sum;
    if (tail_sum > SAT_HI) begin
      sat_nxt = DW'(SAT_HI);
    end else if (tail_sum < SAT_LO) begin
      sat_nxt = DW'(SAT_LO);
    end else begin
      sat_nxt = DW'(tail_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain_vld[MAX_TERMS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= sat_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.sine_value = out_data_r;

  a_stall_freezes_head: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(head_vld_r) && $stable(chain_vld))
    else $error("chain moved while output stalled");

  a_accept_enters_head: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> head_vld_r)
    else $error("accepted beat missing from head stage");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> out_valid_r && $stable(out_data_r))
    else $error("pending result dropped or changed");

endmodule

### rtl/tss_cell.sv
// One series cell: raises the running power by x^2 and adds term TERM_IDX if TERM_IDX <= the beat's last.
// Eight register stages, all advancing on en. Depends on tss_pkg.
module tss_cell #(
  parameter int TERM_IDX = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                up_valid,
  input  tss_pkg::tss_beat_t  up_beat,
  output logic                dn_valid,
  output tss_pkg::tss_beat_t  dn_beat
);

  localparam int DW     = tss_pkg::DATA_W;
  localparam int FB     = tss_pkg::FRAC_BITS;
  localparam int PW     = tss_pkg::PWR_W;
  localparam int HW     = tss_pkg::HALF_W;
  localparam int RW     = tss_pkg::RCP_W;
  localparam int RH     = tss_pkg::RCP_HALF;
  localparam int MW     = tss_pkg::MAG_W;
  localparam int SW     = tss_pkg::SUM_W;
  localparam int IW     = tss_pkg::IDX_W;
  localparam int RB     = tss_pkg::RECIP_BITS;
  localparam int PROD_W = HW + DW;          // half power x angle
  localparam int FULL_W = PROD_W + HW + 1;  // recombined power x angle
  localparam int RP_W   = HW + RH;          // half power x half recip
  localparam int SUB_W  = RP_W + RH + 1;
  localparam int ACC_W  = SUB_W + HW + 1;
  localparam logic [RW-1:0] RCP = RW'(tss_pkg::RECIP_FACT[TERM_IDX]);
  localparam logic [IW-1:0] MY_IDX = IW'(TERM_IDX);
  localparam bit TERM_ODD = (TERM_IDX % 2) == 1;

  logic [7:0]          vld_r;
  tss_pkg::tss_beat_t  b1_r, b2_r, b3_r, b4_r, b5_r, b6_r, b7_r, b8_r;
  logic [PROD_W-1:0]   ph1_r, pl1_r, ph3_r, pl3_r;
  logic [PW-1:0]       m1_r;
  logic [RP_W-1:0]     p00_r, p01_r, p10_r, p11_r;
  logic [SUB_W-1:0]    a_r, c_r;
  logic [MW-1:0]       mag_r;

  logic [FULL_W-1:0]   full2, full4;
  logic [SUB_W-1:0]    a_nxt, c_nxt;
  logic [ACC_W-1:0]    tot;
  tss_pkg::tss_beat_t  b4_nxt, b8_nxt;
  logic signed [SW-1:0] term;

  always_comb begin
    full2 = (FULL_W'(ph1_r) << HW) + FULL_W'(pl1_r);
    full4 = (FULL_W'(ph3_r) << HW) + FULL_W'(pl3_r);
    b4_nxt = b3_r;
    b4_nxt.power = full4[FB +: PW];
    a_nxt = SUB_W'(p00_r) + (SUB_W'(p01_r) << RH);
    c_nxt = SUB_W'(p10_r) + (SUB_W'(p11_r) << RH);
    tot = ACC_W'(a_r) + (ACC_W'(c_r) << HW);
    term = $signed(SW'(mag_r));
    b8_nxt = b7_r;
    if (MY_IDX <= b7_r.last) begin
      if (b7_r.neg ^ TERM_ODD) begin
        b8_nxt.sum = b7_r.sum - term;
      end else begin
        b8_nxt.sum = b7_r.sum + term;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[6:0], up_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // power * |x|
      b1_r  <= up_beat;
      ph1_r <= PROD_W'(up_beat.power[PW-1:HW]) * PROD_W'(up_beat.ax);
      pl1_r <= PROD_W'(up_beat.power[HW-1:0]) * PROD_W'(up_beat.ax);
      b2_r  <= b1_r;
      m1_r  <= full2[FB +: PW];
      // (power * |x|) * |x|
      b3_r  <= b2_r;
      ph3_r <= PROD_W'(m1_r[PW-1:HW]) * PROD_W'(b2_r.ax);
      pl3_r <= PROD_W'(m1_r[HW-1:0]) * PROD_W'(b2_r.ax);
      b4_r  <= b4_nxt;
      // power * 1/(2k+1)!
      b5_r  <= b4_r;
      p00_r <= RP_W'(b4_r.power[HW-1:0]) * RP_W'(RCP[RH-1:0]);
      p01_r <= RP_W'(b4_r.power[HW-1:0]) * RP_W'(RCP[RW-1:RH]);
      p10_r <= RP_W'(b4_r.power[PW-1:HW]) * RP_W'(RCP[RH-1:0]);
      p11_r <= RP_W'(b4_r.power[PW-1:HW]) * RP_W'(RCP[RW-1:RH]);
      b6_r  <= b5_r;
      a_r   <= a_nxt;
      c_r   <= c_nxt;
      b7_r  <= b6_r;
      mag_r <= tot[RB +: MW];
      b8_r  <= b8_nxt;
    end
  end

  assign dn_valid = vld_r[7];
  assign dn_beat  = b8_r;

  // |x| <= 2 keeps every power inside PW bits and every term below 2^DW
  a_power_fits: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> full2[FULL_W-1:FB+PW] == '0)
    else $error("power overflow in cell %0d", TERM_IDX);

  a_term_fits: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] |-> tot[ACC_W-1:RB+DW] == '0)
    else $error("term magnitude overflow in cell %0d", TERM_IDX);

endmodule

### test/tb_taylor_sine_series_top.sv
// Testbench for taylor_sine_series_top: directed and random angles, each result
// checked against an in-bench series predictor or a typed value. Needs tss_pkg, tss_if and the RTL.
module tb_taylor_sine_series_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [tss_pkg::IDX_W-1:0] last;
    logic [31:0]               angle;
    logic                      typed;
    logic [31:0]               sine;
  } probe_t;

  // typed expectations: zero angle, and K = 0 where the sum is x itself
  localparam probe_t DIR_ROWS [24] = '{
    '{3'd4, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{3'd4, 32'h4000_0000, 1'b0, 32'h0},
    '{3'd4, 32'hC000_0000, 1'b0, 32'h0},
    '{3'd4, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{3'd4, 32'h8000_0000, 1'b0, 32'h0},
    '{3'd4, 32'h0000_0001, 1'b0, 32'h0},
    '{3'd4, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{3'd4, 32'h6487_ED51, 1'b0, 32'h0},
    '{3'd0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    '{3'd0, 32'h8000_0000, 1'b1, 32'h8000_0000},
    '{3'd0, 32'h0000_0001, 1'b1, 32'h0000_0001},
    '{3'd0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{3'd0, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{3'd5, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{3'd5, 32'h8000_0000, 1'b0, 32'h0},
    '{3'd5, 32'h6487_ED51, 1'b0, 32'h0},
    '{3'd5, 32'h9B78_12AF, 1'b0, 32'h0},
    '{3'd6, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{3'd6, 32'h8000_0000, 1'b0, 32'h0},
    '{3'd7, 32'h4000_0000, 1'b0, 32'h0},
    '{3'd1, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{3'd1, 32'h8000_0000, 1'b0, 32'h0},
    '{3'd2, 32'h4000_0000, 1'b0, 32'h0},
    '{3'd3, 32'hC000_0000, 1'b0, 32'h0}
  };

  localparam logic [tss_pkg::IDX_W-1:0] PHASE_LAST [8] =
    '{3'd5, 3'd0, 3'd3, 3'd7, 3'd1, 3'd6, 3'd2, 3'd4};
  localparam int PHASE_ITEMS = 75;
  localparam int PIPE_LAT    = 50;

  // round(2^62 / (2k+1)!)
  localparam logic [63:0] INV_ODD_FACT [6] = '{
    64'd4611686018427387904, 64'd768614336404564651, 64'd38430716820228233,
    64'd915017067148291, 64'd12708570377060, 64'd115532457973
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [tss_pkg::IDX_W-1:0] cfg_wdata;

  tss_in_if  in_chan ();
  tss_out_if out_chan ();

  taylor_sine_series_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic [31:0]               sine_q [$];
  logic [tss_pkg::IDX_W-1:0] last_term_cfg;
  idle_mode_t                idle_mode;
  logic                      beat_typed;
  logic [31:0]               beat_sine;
  logic [31:0]               want_sine;
  int                        errors;

  // floor(a * b / 2^s), saturated to 64 bits
  function automatic logic [63:0] mul_shr_sat(input logic [63:0] a, input logic [63:0] b,
                                              input int unsigned s);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> s;
    if (p[127:64] != 64'd0) return '1;
    return p[63:0];
  endfunction

  function automatic logic [31:0] sine_series(input logic [31:0] x,
                                              input logic [tss_pkg::IDX_W-1:0] last_cfg);
    logic        neg;
    logic [63:0] ax;
    logic [63:0] pwr;
    logic [63:0] mag;
    longint      acc;
    int          last;
    neg  = x[31];
    ax   = neg ? (64'h1_0000_0000 - {32'd0, x}) : {32'd0, x};
    last = (last_cfg > 3'd5) ? 5 : int'(last_cfg);
    pwr  = ax;
    acc  = 0;
    for (int k = 0; k <= last; k++) begin
      if (k > 0) begin
        pwr = mul_shr_sat(pwr, ax, 30);
        pwr = mul_shr_sat(pwr, ax, 30);
      end
      mag = mul_shr_sat(pwr, INV_ODD_FACT[k], 62);
      if (mag > (64'd1 << 60)) mag = 64'd1 << 60;
      if (neg != k[0]) acc -= longint'(mag);
      else acc += longint'(mag);
    end
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[31:0];
  endfunction

  function automatic logic [31:0] rand_angle();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom;
      5, 6:          v = $urandom_range(0, 32'h6487_ED51);
      7:             v = $urandom_range(0, 255);
      8:             v = 32'h7FFF_FFFF - $urandom_range(0, 15);
      default:       v = 32'h4000_0000 + $urandom_range(0, 4095) - 2048;
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (idle_mode == IDLE_SNK) out_chan.ready <= ($urandom_range(0, 99) >= 56);
    else if (idle_mode == IDLE_BOTH) out_chan.ready <= ($urandom_range(0, 99) >= 28);
    else out_chan.ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready)
      sine_q.push_back(beat_typed ? beat_sine : sine_series(in_chan.angle, last_term_cfg));
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (sine_q.size() == 0) begin
        $error("sine_value: no beat expected, actual %h", out_chan.sine_value);
        errors++;
      end else begin
        want_sine = sine_q.pop_front();
        if (want_sine !== out_chan.sine_value) begin
          $error("sine_value: expected %h, actual %h", want_sine, out_chan.sine_value);
          errors++;
        end
      end
    end
  end

  // valid is left high after a beat; the next call or drain_results drives it again
  task automatic send_angle(input logic [31:0] a, input logic typed, input logic [31:0] s);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SRC) ? 56 : (idle_mode == IDLE_BOTH) ? 28 : 0;
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    beat_typed = typed;
    beat_sine  = s;
    in_chan.valid <= 1'b1;
    in_chan.angle <= a;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (sine_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_last_term(input logic [tss_pkg::IDX_W-1:0] v);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    last_term_cfg = v;
  endtask

  initial begin
    errors         = 0;
    idle_mode      = IDLE_NONE;
    last_term_cfg  = tss_pkg::LAST_TERM_RST;
    beat_typed     = 1'b0;
    beat_sine      = '0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_chan.valid  = 1'b0;
    in_chan.angle  = '0;
    out_chan.ready = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].last != last_term_cfg) write_last_term(DIR_ROWS[i].last);
      send_angle(DIR_ROWS[i].angle, DIR_ROWS[i].typed, DIR_ROWS[i].sine);
    end

    foreach (PHASE_LAST[p]) begin
      write_last_term(PHASE_LAST[p]);
      idle_mode = idle_mode_t'(p % 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // the second half of every phase runs with no gaps and no back-pressure
        if (n == PHASE_ITEMS / 2) idle_mode = IDLE_NONE;
        send_angle(rand_angle(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (PIPE_LAT) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
